// ===== rtl/core/ncr_pkg.sv =====
package ncr_pkg;

    localparam int FRAC_BITS    = 24;
    localparam int IMAGE_SIZE   = 1024;
    localparam int MAX_ITER_DEF = 4;
    localparam int W            = 8 + FRAC_BITS;
    localparam int PW           = 2 * W + 2;
    localparam int Q24_FRAC     = 24;
    localparam int COORD_W      = 10;
    localparam int Q24_W        = 25;
    localparam int ITER_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 25;
    localparam int NROOT        = 3;
    localparam int DIV_LAT      = W + 3;

    typedef logic signed [W-1:0]  t_fx;
    typedef logic signed [PW-1:0] t_wide;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_COL  = 3'd0,
        CFG_CENTER_ROW  = 3'd1,
        CFG_PIXEL_STEP  = 3'd2,
        CFG_MARKER_THR  = 3'd3,
        CFG_ITER_COUNT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ONE   = 2'd1,
        CLS_UPPER = 2'd2,
        CLS_LOWER = 2'd3
    } t_cls;

    typedef struct packed {
        logic vld;
        logic kill;
        t_fx  re;
        t_fx  im;
    } t_tok;

    typedef struct packed {
        logic [COORD_W-1:0] center_col;
        logic [COORD_W-1:0] center_row;
        logic [Q24_W-1:0]   pixel_step;
        logic [Q24_W-1:0]   marker_threshold;
        logic [ITER_W-1:0]  iteration_count;
    } t_cfg;

    localparam logic [COORD_W-1:0] RST_CENTER_COL = 10'd500;
    localparam logic [COORD_W-1:0] RST_CENTER_ROW = 10'd500;
    localparam logic [Q24_W-1:0]   RST_PIXEL_STEP = 25'd83886;
    localparam logic [Q24_W-1:0]   RST_MARKER_THR = 25'd4194;
    localparam logic [ITER_W-1:0]  RST_ITER_COUNT = 3'd1;

    localparam t_fx FX_MAX      = t_fx'({1'b0, {(W-1){1'b1}}});
    localparam t_fx FX_MIN      = t_fx'({1'b1, {(W-1){1'b0}}});
    localparam t_fx FX_ONE      = t_fx'(W'(1) << FRAC_BITS);
    localparam t_fx FX_HALF_NEG = t_fx'(W'(0) - (W'(1) << (FRAC_BITS - 1)));

    function automatic t_fx fx_sat(t_wide v);
        if (v > t_wide'(FX_MAX)) return FX_MAX;
        if (v < t_wide'(FX_MIN)) return FX_MIN;
        return t_fx'(v);
    endfunction

    function automatic t_fx fx_add(t_fx a, t_fx b);
        return fx_sat(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_fx fx_sub(t_fx a, t_fx b);
        return fx_sat(t_wide'(a) - t_wide'(b));
    endfunction

    // magnitude product, truncated toward zero, saturated by sign
    function automatic t_fx fx_mul(t_fx a, t_fx b);
        logic [W-1:0]   ma;
        logic [W-1:0]   mb;
        logic [2*W-1:0] p;
        logic [2*W-1:0] lim;
        logic           neg;
        ma  = a[W-1] ? W'(-a) : W'(a);
        mb  = b[W-1] ? W'(-b) : W'(b);
        p   = (2*W)'(ma) * (2*W)'(mb);
        p   = p >> FRAC_BITS;
        neg = a[W-1] ^ b[W-1];
        lim = neg ? ((2*W)'(1) << (W-1)) : (((2*W)'(1) << (W-1)) - (2*W)'(1));
        if (p > lim) p = lim;
        return neg ? t_fx'(W'(0) - p[W-1:0]) : t_fx'(p[W-1:0]);
    endfunction

    function automatic logic [FRAC_BITS:0] from_q24(logic [Q24_W-1:0] v);
        logic [FRAC_BITS+Q24_W-1:0] t;
        t = (FRAC_BITS+Q24_W)'(v);
        if (FRAC_BITS >= Q24_FRAC) t = t << (FRAC_BITS - Q24_FRAC);
        else                       t = t >> (Q24_FRAC - FRAC_BITS);
        return t[FRAC_BITS:0];
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v);
        if (int'(v) >= IMAGE_SIZE) return COORD_W'(IMAGE_SIZE - 1);
        return v;
    endfunction

    function automatic t_fx half_sqrt3();
        logic [127:0] t;
        logic [127:0] c;
        logic [127:0] x;
        t = 128'd3 << (2 * FRAC_BITS - 2);
        x = '0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = x | (128'd1 << b);
            if (c * c <= t) x = c;
        end
        return t_fx'(x[W-1:0]);
    endfunction

    localparam t_fx FX_S3     = half_sqrt3();
    localparam t_fx FX_S3_NEG = t_fx'(W'(0) - W'(FX_S3));

endpackage

// ===== rtl/core/ncr_pix_if.sv =====
interface ncr_pix_if import ncr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// ===== rtl/core/ncr_cls_if.sv =====
interface ncr_cls_if import ncr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] root_class;

    modport source (output valid, output root_class, input ready);
    modport sink (input valid, input root_class, output ready);
endinterface

// ===== rtl/core/ncr_dist.sv =====
module ncr_dist import ncr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_fx  i_re,
    input  t_fx  i_im,
    output t_fx  o_d [NROOT]
);

    t_fx r_dx [NROOT];
    t_fx r_dy [NROOT];
    t_fx r_sx [NROOT];
    t_fx r_sy [NROOT];
    t_fx r_d  [NROOT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx[0] <= fx_sub(i_re, FX_ONE);
            r_dy[0] <= i_im;
            r_dx[1] <= fx_sub(i_re, FX_HALF_NEG);
            r_dy[1] <= fx_sub(i_im, FX_S3);
            r_dx[2] <= fx_sub(i_re, FX_HALF_NEG);
            r_dy[2] <= fx_sub(i_im, FX_S3_NEG);
            for (int k = 0; k < NROOT; k++) begin
                r_sx[k] <= fx_mul(r_dx[k], r_dx[k]);
                r_sy[k] <= fx_mul(r_dy[k], r_dy[k]);
                r_d[k]  <= fx_add(r_sx[k], r_sy[k]);
            end
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/core/ncr_div.sv =====
module ncr_div import ncr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_fx  i_a,
    input  t_fx  i_d,
    output t_fx  o_q
);

    localparam int NB = W + 1;

    logic [W-2:0] r_rem [NB+1];
    logic [W:0]   r_n   [NB+1];
    logic [W:0]   r_q   [NB+1];
    logic [W-2:0] r_dv  [NB+1];
    logic         r_neg [NB+1];
    logic         r_ovf [NB+1];
    t_fx          r_res;

    logic [W-1:0]           w_ma;
    logic [W+FRAC_BITS-1:0] w_num;
    logic [FRAC_BITS-2:0]   w_hi;
    logic [W:0]             w_lim;
    logic [W:0]             w_mag;

    assign w_ma  = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign w_num = {w_ma, {FRAC_BITS{1'b0}}};
    assign w_hi  = w_num[W+FRAC_BITS-1:W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (W-1)'(w_hi);
            r_n[0]   <= w_num[W:0];
            r_q[0]   <= '0;
            r_dv[0]  <= i_d[W-2:0];
            r_neg[0] <= i_a[W-1];
            r_ovf[0] <= W'(w_hi) >= W'(i_d[W-2:0]);
        end
    end

    for (genvar k = 1; k <= NB; k++) begin : g_bit
        logic [W-1:0] w_rem2;
        logic [W-1:0] w_sub;
        logic         w_ge;

        assign w_rem2 = {r_rem[k-1], r_n[k-1][W]};
        assign w_ge   = w_rem2 >= {1'b0, r_dv[k-1]};
        assign w_sub  = w_rem2 - {1'b0, r_dv[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_sub[W-2:0] : w_rem2[W-2:0];
                r_n[k]   <= {r_n[k-1][W-1:0], 1'b0};
                r_q[k]   <= {r_q[k-1][W-1:0], w_ge};
                r_dv[k]  <= r_dv[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        w_lim = r_neg[NB] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
        w_mag = (r_ovf[NB] || (r_q[NB] > w_lim)) ? w_lim : r_q[NB];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_neg[NB] ? t_fx'(W'(0) - w_mag[W-1:0]) : t_fx'(w_mag[W-1:0]);
        end
    end

    assign o_q = r_res;

endmodule

// ===== rtl/core/ncr_cell.sv =====
module ncr_cell import ncr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_active,
    input  t_tok i_tok,
    output t_tok o_tok
);

    typedef struct packed {
        t_tok tok;
        t_fx  nre;
        t_fx  nim;
        logic dpos;
    } t_side;

    t_tok  r1_tok;
    t_tok  r2_tok;
    t_tok  r3_tok;
    t_tok  r4_tok;
    t_tok  r5_tok;
    t_tok  r7_tok;
    t_tok  r8_tok;
    t_side r_sd [DIV_LAT];
    logic  r7_dpos;

    t_fx r1_p [4];
    t_fx r2_z2re;
    t_fx r2_z2im;
    t_fx r3_q [4];
    t_fx r3_wre;
    t_fx r3_wim;
    t_fx r4_nre;
    t_fx r4_nim;
    t_fx r4_m0;
    t_fx r4_m1;
    t_fx r4_wre;
    t_fx r4_wim;
    t_fx r5_d;
    t_fx r5_wre;
    t_fx r5_nwim;
    t_fx r5_nre;
    t_fx r5_nim;
    t_fx r7_g [4];

    t_fx  w_rre;
    t_fx  w_rim;
    logic w_dpos;
    t_tok n_tok;

    assign w_dpos = !r5_d[W-1] && (r5_d != '0);

    ncr_div u_div_re (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r5_wre),
        .i_d   (r5_d),
        .o_q   (w_rre)
    );

    ncr_div u_div_im (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r5_nwim),
        .i_d   (r5_d),
        .o_q   (w_rim)
    );

    // newton update, or undefined step when |3z^2|^2 is not positive
    always_comb begin
        n_tok = r7_tok;
        if (!r7_tok.kill && i_active) begin
            if (!r7_dpos) begin
                n_tok.kill = 1'b1;
            end else begin
                n_tok.re = fx_sub(r7_tok.re, fx_sub(r7_g[0], r7_g[1]));
                n_tok.im = fx_sub(r7_tok.im, fx_add(r7_g[2], r7_g[3]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tok  <= '0;
            r2_tok  <= '0;
            r3_tok  <= '0;
            r4_tok  <= '0;
            r5_tok  <= '0;
            r7_tok  <= '0;
            r8_tok  <= '0;
            r7_dpos <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sd[k] <= '0;
            end
        end else if (i_en) begin
            r1_tok  <= i_tok;
            r2_tok  <= r1_tok;
            r3_tok  <= r2_tok;
            r4_tok  <= r3_tok;
            r5_tok  <= r4_tok;
            r_sd[0] <= '{tok: r5_tok, nre: r5_nre, nim: r5_nim, dpos: w_dpos};
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r7_tok  <= r_sd[DIV_LAT-1].tok;
            r7_dpos <= r_sd[DIV_LAT-1].dpos;
            r8_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // z^2
            r1_p[0] <= fx_mul(i_tok.re, i_tok.re);
            r1_p[1] <= fx_mul(i_tok.im, i_tok.im);
            r1_p[2] <= fx_mul(i_tok.im, i_tok.re);
            r1_p[3] <= fx_mul(i_tok.re, i_tok.im);
            r2_z2re <= fx_sub(r1_p[0], r1_p[1]);
            r2_z2im <= fx_add(r1_p[2], r1_p[3]);
            // z^3 and 3z^2
            r3_q[0] <= fx_mul(r2_z2re, r2_tok.re);
            r3_q[1] <= fx_mul(r2_z2im, r2_tok.im);
            r3_q[2] <= fx_mul(r2_z2im, r2_tok.re);
            r3_q[3] <= fx_mul(r2_z2re, r2_tok.im);
            r3_wre  <= fx_add(fx_add(r2_z2re, r2_z2re), r2_z2re);
            r3_wim  <= fx_add(fx_add(r2_z2im, r2_z2im), r2_z2im);
            r4_nre  <= fx_sub(fx_sub(r3_q[0], r3_q[1]), FX_ONE);
            r4_nim  <= fx_add(r3_q[2], r3_q[3]);
            r4_m0   <= fx_mul(r3_wre, r3_wre);
            r4_m1   <= fx_mul(r3_wim, r3_wim);
            r4_wre  <= r3_wre;
            r4_wim  <= r3_wim;
            r5_d    <= fx_add(r4_m0, r4_m1);
            r5_wre  <= r4_wre;
            r5_nwim <= fx_sub('0, r4_wim);
            r5_nre  <= r4_nre;
            r5_nim  <= r4_nim;
            // numerator times reciprocal
            r7_g[0] <= fx_mul(r_sd[DIV_LAT-1].nre, w_rre);
            r7_g[1] <= fx_mul(r_sd[DIV_LAT-1].nim, w_rim);
            r7_g[2] <= fx_mul(r_sd[DIV_LAT-1].nim, w_rre);
            r7_g[3] <= fx_mul(r_sd[DIV_LAT-1].nre, w_rim);
        end
    end

    assign o_tok = r8_tok;

endmodule

// ===== rtl/core/ncr_head.sv =====
module ncr_head import ncr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [COORD_W-1:0] i_col,
    input  logic [COORD_W-1:0] i_row,
    input  t_cfg               i_cfg,
    output t_tok               o_tok
);

    logic               r0_vld;
    logic [COORD_W-1:0] r0_col;
    logic [COORD_W-1:0] r0_row;
    t_tok               r1_tok;
    t_tok               r_dl [NROOT];
    t_tok               r_out;

    logic signed [COORD_W:0] w_dcol;
    logic signed [COORD_W:0] w_drow;
    logic [FRAC_BITS:0]      w_step;
    logic [FRAC_BITS:0]      w_thr;
    t_fx                     w_d [NROOT];
    t_tok                    n_tok;

    assign w_dcol = $signed({1'b0, clamp_coord(r0_col)})
                  - $signed({1'b0, clamp_coord(i_cfg.center_col)});
    assign w_drow = $signed({1'b0, clamp_coord(r0_row)})
                  - $signed({1'b0, clamp_coord(i_cfg.center_row)});
    assign w_step = from_q24(i_cfg.pixel_step);
    assign w_thr  = from_q24(i_cfg.marker_threshold);

    ncr_dist u_dist (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_re  (r1_tok.re),
        .i_im  (r1_tok.im),
        .o_d   (w_d)
    );

    // start point near a root is drawn as a marker dot
    always_comb begin
        n_tok = r_dl[NROOT-1];
        if (w_d[0] < t_fx'(w_thr) || w_d[1] < t_fx'(w_thr) || w_d[2] < t_fx'(w_thr)) begin
            n_tok.kill = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld     <= 1'b0;
            r1_tok.vld <= 1'b0;
            r_out.vld  <= 1'b0;
            for (int k = 0; k < NROOT; k++) begin
                r_dl[k].vld <= 1'b0;
            end
        end else if (i_en) begin
            r0_vld      <= i_vld;
            r0_col      <= i_col;
            r0_row      <= i_row;
            r1_tok.vld  <= r0_vld;
            r1_tok.kill <= 1'b0;
            r1_tok.re   <= fx_sat(t_wide'(w_dcol) * t_wide'({1'b0, w_step}));
            r1_tok.im   <= fx_sat(t_wide'(w_drow) * t_wide'({1'b0, w_step}));
            r_dl[0]     <= r1_tok;
            for (int k = 1; k < NROOT; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
            r_out       <= n_tok;
        end
    end

    assign o_tok = r_out;

endmodule

// ===== rtl/core/newton_cubic_root_classifier_unit.sv =====
// Newton fractal classifier for z^3 - 1: takes one pixel coordinate pair per transfer and
// returns the cube root of unity that MAX_ITERATIONS-bounded Newton steps from the mapped
// start point end nearest to (0 for a marker dot, a tie or an undefined step). A new pixel
// is taken every cycle while the pipeline is not halted. The pipeline is a chain of Newton
// cells, each carrying two bit-per-stage restoring dividers of W + 1 quotient bits, where W
// is the Q8.FRAC_BITS word width. Steps beyond the programmed iteration count pass the
// point through unchanged, so the latency does not depend on the count. The pipeline halts
// only while an unaccepted result sits in the output register and the next result is
// ready behind it.
module newton_cubic_root_classifier_unit import ncr_pkg::*; #(
    parameter int MAX_ITERATIONS = MAX_ITER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ncr_pix_if.sink               i_pix,
    ncr_cls_if.source             o_cls
);

    t_cfg       r_cfg;
    t_tok       r_tl [NROOT];
    logic       r_out_vld;
    logic [1:0] r_out_cls;

    logic w_en;
    logic w_last_vld;
    t_tok w_tok [MAX_ITERATIONS+1];
    t_fx  w_d [NROOT];
    t_cls n_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_col       <= RST_CENTER_COL;
            r_cfg.center_row       <= RST_CENTER_ROW;
            r_cfg.pixel_step       <= RST_PIXEL_STEP;
            r_cfg.marker_threshold <= RST_MARKER_THR;
            r_cfg.iteration_count  <= RST_ITER_COUNT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_COL: r_cfg.center_col       <= i_cfg_data[COORD_W-1:0];
                CFG_CENTER_ROW: r_cfg.center_row       <= i_cfg_data[COORD_W-1:0];
                CFG_PIXEL_STEP: r_cfg.pixel_step       <= i_cfg_data[Q24_W-1:0];
                CFG_MARKER_THR: r_cfg.marker_threshold <= i_cfg_data[Q24_W-1:0];
                CFG_ITER_COUNT: r_cfg.iteration_count  <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_last_vld  = r_tl[NROOT-1].vld;
    assign w_en        = !(r_out_vld && !o_cls.ready && w_last_vld);
    assign i_pix.ready = w_en;

    ncr_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_col   (i_pix.pixel_col),
        .i_row   (i_pix.pixel_row),
        .i_cfg   (r_cfg),
        .o_tok   (w_tok[0])
    );

    for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_cell
        logic w_act;

        assign w_act = int'(r_cfg.iteration_count) > k;

        ncr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_active (w_act),
            .i_tok    (w_tok[k]),
            .o_tok    (w_tok[k+1])
        );
    end

    ncr_dist u_dist (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_re  (w_tok[MAX_ITERATIONS].re),
        .i_im  (w_tok[MAX_ITERATIONS].im),
        .o_d   (w_d)
    );

    always_comb begin
        if (r_tl[NROOT-1].kill) begin
            n_cls = CLS_NONE;
        end else if (w_d[0] < w_d[1] && w_d[0] < w_d[2]) begin
            n_cls = CLS_ONE;
        end else if (w_d[1] < w_d[0] && w_d[1] < w_d[2]) begin
            n_cls = CLS_UPPER;
        end else if (w_d[2] < w_d[0] && w_d[2] < w_d[1]) begin
            n_cls = CLS_LOWER;
        end else begin
            n_cls = CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int k = 0; k < NROOT; k++) begin
                r_tl[k] <= '0;
            end
        end else begin
            r_out_vld <= (w_en && w_last_vld) || (r_out_vld && !o_cls.ready);
            if (w_en) begin
                r_tl[0] <= w_tok[MAX_ITERATIONS];
                for (int k = 1; k < NROOT; k++) begin
                    r_tl[k] <= r_tl[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_last_vld) begin
            r_out_cls <= n_cls;
        end
    end

    assign o_cls.valid      = r_out_vld;
    assign o_cls.root_class = r_out_cls;

endmodule

// ===== rtl/core/ncr_chk.sv =====
module ncr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_root_class
);

    // input side only waits on a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    a_rst_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_root_class))
        else $error("result changed while stalled");

endmodule

bind newton_cubic_root_classifier_unit ncr_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_cls.valid),
    .i_out_ready  (o_cls.ready),
    .i_root_class (o_cls.root_class)
);

// ===== tb/tb.sv =====
module tb;
    import ncr_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_C = 3'd7;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint Q_ONE = 64'sd16777216;

    typedef struct {
        longint re;
        longint im;
    } t_cpx;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        bit                 typed;
        t_cls               cls;
    } t_pix_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ncr_pix_if pix ();
    ncr_cls_if cls ();

    newton_cubic_root_classifier_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix),
        .o_cls      (cls)
    );

    logic [COORD_W-1:0] m_col;
    logic [COORD_W-1:0] m_row;
    logic [Q24_W-1:0]   m_step;
    logic [Q24_W-1:0]   m_thr;
    logic [ITER_W-1:0]  m_iter;

    t_cls   expected_cls[$];
    int     errors;
    int     cycles;
    bit     idle_on;
    int     hold_cycles;
    longint root_im;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    function automatic longint clip(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    function automatic longint signed_limit(bit neg, logic [63:0] m);
        logic [63:0] lim;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        return signed_limit((a < 0) != (b < 0), (ma * mb) >> FRAC_BITS);
    endfunction

    function automatic longint qdiv(longint a, longint d);
        logic [63:0] ua;
        ua = a < 0 ? -a : a;
        return signed_limit(a < 0, (ua << FRAC_BITS) / 64'(d));
    endfunction

    function automatic t_cpx cmul(t_cpx a, t_cpx b);
        t_cpx r;
        r.re = clip(qmul(a.re, b.re) - qmul(a.im, b.im));
        r.im = clip(qmul(a.im, b.re) + qmul(a.re, b.im));
        return r;
    endfunction

    function automatic longint root_dist(t_cpx z, longint rr, longint ri);
        longint dx;
        longint dy;
        dx = clip(z.re - rr);
        dy = clip(z.im - ri);
        return clip(qmul(dx, dx) + qmul(dy, dy));
    endfunction

    function automatic longint sqrt3_half();
        logic [127:0] target;
        logic [127:0] x;
        logic [127:0] c;
        target = 128'd3 << (2 * FRAC_BITS - 2);
        x = '0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = x | (128'd1 << b);
            if (c * c <= target) x = c;
        end
        return longint'(x[63:0]);
    endfunction

    function automatic t_cls classify_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        t_cpx   z;
        t_cpx   z2;
        t_cpx   num;
        t_cpx   w;
        t_cpx   rec;
        t_cpx   grad;
        longint half;
        longint thr;
        longint d;
        longint d1;
        longint d2;
        longint d3;
        int     n;
        half = -(Q_ONE / 2);
        thr  = longint'(m_thr);
        z.re = clip((longint'(col) - longint'(m_col)) * longint'(m_step));
        z.im = clip((longint'(row) - longint'(m_row)) * longint'(m_step));
        if (root_dist(z, Q_ONE, 0) < thr || root_dist(z, half, root_im) < thr ||
            root_dist(z, half, -root_im) < thr)
            return CLS_NONE;
        n = m_iter > MAX_ITER_DEF ? MAX_ITER_DEF : int'(m_iter);
        for (int it = 0; it < n; it++) begin
            z2 = cmul(z, z);
            num = cmul(z2, z);
            num.re = clip(num.re - Q_ONE);
            w.re = clip(clip(z2.re + z2.re) + z2.re);
            w.im = clip(clip(z2.im + z2.im) + z2.im);
            d = clip(qmul(w.re, w.re) + qmul(w.im, w.im));
            if (d <= 0) return CLS_NONE;
            rec.re = qdiv(w.re, d);
            rec.im = qdiv(clip(-w.im), d);
            grad = cmul(num, rec);
            z.re = clip(z.re - grad.re);
            z.im = clip(z.im - grad.im);
        end
        d1 = root_dist(z, Q_ONE, 0);
        d2 = root_dist(z, half, root_im);
        d3 = root_dist(z, half, -root_im);
        if (d1 < d2 && d1 < d3) return CLS_ONE;
        if (d2 < d1 && d2 < d3) return CLS_UPPER;
        if (d3 < d1 && d3 < d2) return CLS_LOWER;
        return CLS_NONE;
    endfunction

    // result side: check each transfer, random ready bursts, long hold on request
    initial begin
        int burst;
        t_cls want;
        burst = 0;
        cls.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && cls.valid && cls.ready) begin
                if (expected_cls.size() == 0) begin
                    $display("%0t: unexpected result %0d", $time, cls.root_class);
                    errors++;
                end else begin
                    want = expected_cls.pop_front();
                    if (cls.root_class !== want) begin
                        $display("%0t: root_class expected %0d actual %0d",
                                 $time, want, cls.root_class);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                cls.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                cls.ready <= 1'b0;
            end else begin
                if (idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 8);
                cls.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_CENTER_COL: m_col  = val[COORD_W-1:0];
            CFG_CENTER_ROW: m_row  = val[COORD_W-1:0];
            CFG_PIXEL_STEP: m_step = val[Q24_W-1:0];
            CFG_MARKER_THR: m_thr  = val[Q24_W-1:0];
            CFG_ITER_COUNT: m_iter = val[ITER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (expected_cls.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(logic [9:0] c, logic [9:0] r, logic [24:0] s, logic [24:0] t,
                               logic [2:0] n);
        wait_drained();
        write_reg(CFG_CENTER_COL, 25'(c));
        write_reg(CFG_CENTER_ROW, 25'(r));
        write_reg(CFG_PIXEL_STEP, s);
        write_reg(CFG_MARKER_THR, t);
        write_reg(CFG_ITER_COUNT, 25'(n));
    endtask

    // one pixel transfer; the class is predicted unless given
    task automatic push_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              bit typed, t_cls cls_in);
        pix.valid     <= 1'b1;
        pix.pixel_col <= col;
        pix.pixel_row <= row;
        do @(posedge i_clk); while (!pix.ready);
        expected_cls.push_back(typed ? cls_in : classify_pixel(col, row));
        if (idle_on && $urandom_range(0, 4) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic random_pixel();
        int c;
        int r;
        if ($urandom_range(0, 1) == 0) begin
            c = $urandom_range(0, 1023);
            r = $urandom_range(0, 1023);
        end else begin
            c = int'(m_col) + $urandom_range(0, 80) - 40;
            r = int'(m_row) + $urandom_range(0, 80) - 40;
            c = c < 0 ? 0 : (c > 1023 ? 1023 : c);
            r = r < 0 ? 0 : (r > 1023 ? 1023 : r);
        end
        push_pixel(COORD_W'(c), COORD_W'(r), 1'b0, CLS_NONE);
    endtask

    t_pix_row directed[] = '{
        '{10'd500,  10'd500,  1'b1, CLS_NONE},
        '{10'd700,  10'd500,  1'b1, CLS_NONE},
        '{10'd512,  10'd500,  1'b0, CLS_NONE},
        '{10'd0,    10'd0,    1'b0, CLS_NONE},
        '{10'd1023, 10'd1023, 1'b0, CLS_NONE},
        '{10'd0,    10'd1023, 1'b0, CLS_NONE},
        '{10'd1023, 10'd0,    1'b0, CLS_NONE},
        '{10'd400,  10'd327,  1'b0, CLS_NONE},
        '{10'd400,  10'd673,  1'b0, CLS_NONE},
        '{10'd300,  10'd500,  1'b0, CLS_NONE},
        '{10'd500,  10'd300,  1'b0, CLS_NONE},
        '{10'd650,  10'd620,  1'b0, CLS_NONE},
        '{10'd501,  10'd500,  1'b0, CLS_NONE}
    };

    initial begin
        errors      = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        root_im     = sqrt3_half();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        pix.valid   = 1'b0;
        pix.pixel_col = '0;
        pix.pixel_row = '0;
        m_col  = RST_CENTER_COL;
        m_row  = RST_CENTER_ROW;
        m_step = RST_PIXEL_STEP;
        m_thr  = RST_MARKER_THR;
        m_iter = RST_ITER_COUNT;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            push_pixel(directed[k].col, directed[k].row, directed[k].typed, directed[k].cls);
        repeat (160) random_pixel();

        load_config(10'd512, 10'd512, 25'd4194304, 25'd0, 3'd4);
        repeat (170) random_pixel();

        load_config(10'd0, 10'd0, 25'd16777216, 25'd16777216, 3'd7);
        repeat (170) random_pixel();

        load_config(10'd1023, 10'd1023, 25'd1, 25'd1, 3'd2);
        repeat (170) random_pixel();

        load_config(10'd300, 10'd700, 25'h1FFFFFF, 25'h1FFFFFF, 3'd0);
        repeat (170) random_pixel();

        load_config(10'd511, 10'd511, 25'd65536, 25'd1000, 3'd3);
        write_reg(CFG_SPARE_A, 25'h1FFFFFF);
        write_reg(CFG_SPARE_B, 25'h0AAAAAA);
        write_reg(CFG_SPARE_C, 25'h1555555);
        repeat (80) random_pixel();
        wait_drained();
        repeat (90) random_pixel();

        load_config(10'd500, 10'd500, 25'd167772, 25'd4194, 3'd4);
        repeat (20) random_pixel();
        hold_cycles = 500;
        repeat (150) random_pixel();

        load_config(10'd200, 10'd800, 25'd0, 25'd0, 3'd1);
        repeat (40) random_pixel();

        load_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                    25'($urandom_range(1, 1 << 22)), 25'($urandom_range(0, 1 << 16)),
                    3'($urandom_range(1, 4)));
        idle_on = 1'b0;
        repeat (260) random_pixel();

        pix.valid <= 1'b0;
        while (expected_cls.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ncr_pkg.sv
rtl/core/ncr_pix_if.sv
rtl/core/ncr_cls_if.sv
rtl/core/ncr_dist.sv
rtl/core/ncr_div.sv
rtl/core/ncr_cell.sv
rtl/core/ncr_head.sv
rtl/core/newton_cubic_root_classifier_unit.sv
rtl/core/ncr_chk.sv
tb/tb.sv
